### sv/ihc_pkg.sv
// Package with the word types, opcodes and constants of the hexadecimal float converter.
package ihc_pkg;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_DECODE = 2'd1,
    OP_FLOOR  = 2'd2,
    OP_ULP    = 2'd3
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [63:0] double_bits;
    logic [31:0] ibm_word;
  } in_word_t;

  typedef struct packed {
    logic [31:0] ibm_result;
    logic [63:0] value_bits;
    logic        status;
  } out_word_t;

  // Binary64 biased exponent of 16^-65, the smallest normal hex magnitude.
  localparam logic [10:0] EXP_TINY = 11'd763;
  // Binary64 biased exponent of the binade holding the largest hex magnitude.
  localparam logic [10:0] EXP_TOP  = 11'd1274;
  // Binary64 biased exponent of 16^(c-70) is 4*c + EXP_OFS.
  localparam logic [10:0] EXP_OFS  = 11'd743;

  localparam logic [23:0] FRAC_MIN      = 24'h100000;
  localparam logic [31:0] TINY_NEG_WORD = 32'h80100000;
  localparam logic [6:0]  EXP_HEX_MAX   = 7'd127;

endpackage

### sv/ieee_double_ibm_hexfloat_convert_core.sv
// Top level of the converter pipeline between binary64 and IBM hexadecimal float32.
//
// The block takes one word on the input channel (in_valid_i, in_ready_o,
// in_data_i) holding an opcode, a binary64 pattern and an IBM word, and
// returns one word on the output channel (out_valid_o, out_ready_i,
// out_data_o) holding the IBM result, a binary64 result and a status bit.
// Opcode encode rounds to the nearest IBM word (half up on the magnitude),
// decode turns an IBM word into binary64, floor rounds toward minus infinity
// and also returns the value of that word, and ulp returns the unit in the
// last place of the input's IBM binade. Status is set, but never for decode,
// when the input is not finite or lies beyond the largest IBM magnitude.
//
// There are three register stages: a classify and align stage, a rounding
// stage and a binary64 normalize stage whose register drives the output. A
// word accepted into stage 1 moves through stage 2 to the output register,
// and a new word may enter in every cycle in which in_ready_o is high.
// The whole pipeline advances together: when the output word is not taken,
// in_ready_o drops and every stage holds, empty stages included, so nothing
// is lost or repeated. Reset clears all stage valid bits; the data
// registers are not reset.
module ieee_double_ibm_hexfloat_convert_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ihc_pkg::in_word_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ihc_pkg::out_word_t out_data_o
);
  import ihc_pkg::*;

  logic adv;

  // Stage 1: classify the binary64 input and align its mantissa to the
  // hex fraction grid.
  logic [10:0] ex_w;
  logic [51:0] fr_w;
  logic [52:0] mant_w;
  logic [10:0] t_w;
  logic [23:0] mtr_w;
  logic        rb_w, stk_w;
  logic        ovf_w, tiny_w, nz_w, vmin_le_w;

  logic        v1_q;
  op_e         op1_q;
  logic        sgn1_q, nz1_q, tiny1_q, ovf1_q, vmin_le1_q, rb1_q, stk1_q;
  logic [6:0]  e1_q;
  logic [23:0] mtr1_q;
  logic [31:0] word1_q;

  // Stage 2: rounding and word assembly.
  logic [24:0] near_w, up_w;
  logic [31:0] wnear_w, wfloor_w, res_w, dec_in_w;
  logic [6:0]  ecap_w;
  logic [63:0] ulp_w;

  logic        v2_q;
  op_e         op2_q;
  logic        st2_q;
  logic [31:0] res2_q, dec2_q;
  logic [63:0] ulp2_q;

  // Stage 3: binary64 normalize of an IBM word.
  logic [6:0]  c_w;
  logic [23:0] m_w, mn_w;
  logic [4:0]  msb_w;
  logic [10:0] dexp_w;
  logic [63:0] dval_w, val_w;

  logic        v3_q;
  out_word_t   out_q;

  assign adv        = ~v3_q | out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    ex_w      = in_data_i.double_bits[62:52];
    fr_w      = in_data_i.double_bits[51:0];
    mant_w    = {1'b1, fr_w};
    nz_w      = (ex_w != 11'd0) | (fr_w != 52'd0);
    tiny_w    = ex_w < EXP_TINY;
    // Not finite, or in the top binade above 0xffffff * 16^57.
    ovf_w     = (ex_w > EXP_TOP) |
                ((ex_w == EXP_TOP) & (&fr_w[51:29]) & (fr_w[28:0] != 29'd0));
    vmin_le_w = tiny_w | ((ex_w == EXP_TINY) & (fr_w == 52'd0));
    t_w       = ex_w - EXP_TINY;
    case (t_w[1:0])
      2'd0: begin
        mtr_w = {3'b0, mant_w[52:32]};
        rb_w  = mant_w[31];
        stk_w = |mant_w[31:0];
      end
      2'd1: begin
        mtr_w = {2'b0, mant_w[52:31]};
        rb_w  = mant_w[30];
        stk_w = |mant_w[30:0];
      end
      2'd2: begin
        mtr_w = {1'b0, mant_w[52:30]};
        rb_w  = mant_w[29];
        stk_w = |mant_w[29:0];
      end
      default: begin
        mtr_w = mant_w[52:29];
        rb_w  = mant_w[28];
        stk_w = |mant_w[28:0];
      end
    endcase
  end

  always_comb begin
    near_w = {1'b0, mtr1_q} + {24'd0, rb1_q};
    up_w   = {1'b0, mtr1_q} + {24'd0, stk1_q};
    // A fraction that rounds up out of 24 bits renormalizes one hex digit up.
    if (near_w[24]) begin
      wnear_w = {sgn1_q, e1_q + 7'd1, FRAC_MIN};
    end else begin
      wnear_w = {sgn1_q, e1_q, near_w[23:0]};
    end
    if (!sgn1_q) begin
      wfloor_w = {1'b0, e1_q, mtr1_q};
    end else if (up_w[24]) begin
      wfloor_w = {1'b1, e1_q + 7'd1, FRAC_MIN};
    end else begin
      wfloor_w = {1'b1, e1_q, up_w[23:0]};
    end
    if (tiny1_q) begin
      wnear_w  = {sgn1_q & nz1_q, 31'd0};
      wfloor_w = (sgn1_q & nz1_q) ? TINY_NEG_WORD : 32'd0;
    end
    case (op1_q)
      OP_ENCODE: res_w = ovf1_q ? 32'd0 : wnear_w;
      OP_FLOOR:  res_w = ovf1_q ? 32'd0 : wfloor_w;
      default:   res_w = 32'd0;
    endcase
    dec_in_w = (op1_q == OP_DECODE) ? word1_q : res_w;
    ecap_w   = (e1_q == EXP_HEX_MAX) ? EXP_HEX_MAX - 7'd1 : e1_q;
    if (ovf1_q) begin
      ulp_w = 64'd0;
    end else if (vmin_le1_q) begin
      ulp_w = {1'b0, EXP_TINY, 52'd0};
    end else begin
      ulp_w = {1'b0, {2'b0, ecap_w, 2'b0} + EXP_OFS, 52'd0};
    end
  end

  always_comb begin
    c_w   = dec2_q[30:24];
    m_w   = dec2_q[23:0];
    msb_w = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (m_w[i]) begin
        msb_w = 5'(i);
      end
    end
    mn_w   = m_w << (5'd23 - msb_w);
    dexp_w = {6'd0, msb_w} + {2'b0, c_w, 2'b0} + EXP_OFS;
    if ((c_w == 7'd0) && (m_w <= 24'd1)) begin
      dval_w = 64'd0;
    end else if (m_w == 24'd0) begin
      dval_w = {dec2_q[31], 63'd0};
    end else begin
      dval_w = {dec2_q[31], dexp_w, mn_w[22:0], 29'd0};
    end
    case (op2_q) inside
      OP_DECODE, OP_FLOOR: val_w = dval_w;
      OP_ULP:              val_w = ulp2_q;
      default:             val_w = 64'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q      <= in_data_i.opcode;
      sgn1_q     <= in_data_i.double_bits[63];
      nz1_q      <= nz_w;
      tiny1_q    <= tiny_w;
      ovf1_q     <= ovf_w;
      vmin_le1_q <= vmin_le_w;
      e1_q       <= t_w[8:2];
      mtr1_q     <= mtr_w;
      rb1_q      <= rb_w;
      stk1_q     <= stk_w;
      word1_q    <= in_data_i.ibm_word;

      op2_q  <= op1_q;
      st2_q  <= (op1_q != OP_DECODE) & ovf1_q;
      res2_q <= res_w;
      dec2_q <= dec_in_w;
      ulp2_q <= ulp_w;

      out_q.ibm_result <= res2_q;
      out_q.value_bits <= val_w;
      out_q.status     <= st2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = out_q;

endmodule
